### hdl/assert_macros.svh
// assertion macros used by the controller top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/lutxf_pkg.sv
// types and constants of the lut layer crossfade controller
package lutxf_pkg;

  localparam int MaxLayers        = 8;
  localparam int IdxW             = $clog2(MaxLayers);
  localparam int CntW             = $clog2(MaxLayers + 1);
  localparam int WeightBits       = 16;
  localparam int WeightW          = WeightBits + 1;
  localparam int TimeW            = 16;
  localparam int IdW              = 16;
  localparam int InstantThreshold = 10;
  localparam int DivCntW          = $clog2(WeightBits);

  localparam logic [WeightW-1:0] One = WeightW'(1) << WeightBits;

  // request action codes
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_FADE,
    ST_DIV,
    ST_LOWER,
    ST_COMPACT,
    ST_EMIT
  } state_e;

endpackage

### hdl/lut_layer_crossfade_controller_top.sv
// lut layer crossfade controller: layer stack, fade sequencer and output register
// add, clear and unused-action requests are handled in IDLE and can follow back to back
// a tick steps through APPLY when a latched chart is pending, then FADE; an empty stack
// ends there, else DIV (16 divider steps, skipped when the top layer is complete or alone),
// LOWER over the layers below the top, COMPACT over every layer and EMIT per kept layer
// reset clears the count, the pending chart and the output valid; layer entries are not reset
`include "assert_macros.svh"

module lut_layer_crossfade_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic [lutxf_pkg::IdW-1:0]         chart_id_i,
  input  logic [lutxf_pkg::TimeW-1:0]       fade_time_i,
  input  logic [lutxf_pkg::TimeW-1:0]       frame_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lutxf_pkg::IdW-1:0]         layer_chart_o,
  output logic [lutxf_pkg::WeightW-1:0]     layer_weight_o,
  output logic                              last_layer_o
);
  import lutxf_pkg::*;

  // control state
  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q;
  logic [IdxW-1:0]      idx_q;
  logic [CntW-1:0]      kept_q;
  logic [DivCntW-1:0]   divcnt_q;
  logic                 pend_valid_q;
  logic [IdW-1:0]       pend_chart_q;
  logic [TimeW-1:0]     pend_time_q;
  logic                 out_valid_q;

  // datapath state
  logic [TimeW-1:0]     frame_q;
  logic [WeightW-1:0]   tw_q;
  logic [WeightBits-1:0] quo_q;
  logic [TimeW-1:0]     rem_q;
  logic [IdW-1:0]       out_chart_q;
  logic [WeightW-1:0]   out_weight_q;
  logic                 out_last_q;

  // layer stack
  logic [IdW-1:0]       ids_q  [MaxLayers];
  logic [WeightW-1:0]   wgt_q  [MaxLayers];
  logic [WeightW-1:0]   peak_q [MaxLayers];
  logic [TimeW-1:0]     elap_q [MaxLayers];
  logic [TimeW-1:0]     dur_q  [MaxLayers];

  // decoded and derived values
  logic                 in_fire;
  logic                 out_load;
  action_e              act;
  logic [CntW-1:0]      cnt_m1;
  logic [IdxW-1:0]      top_idx;
  logic [IdxW-1:0]      top_m1;
  logic                 full;
  logic [IdxW-1:0]      push_idx;
  logic                 pend_instant;
  logic [TimeW-1:0]     dur_top;
  logic [TimeW:0]       elap_sum;
  logic [TimeW-1:0]     elap_sat;
  logic                 top_complete;
  logic [TimeW:0]       rem2;
  logic [TimeW:0]       rem_sub;
  logic                 div_ge;
  logic [TimeW-1:0]     rem_nxt;
  logic [WeightBits-1:0] quo_nxt;
  logic [WeightW-1:0]   fade_f;
  logic [2*WeightW-1:0] prod;
  logic                 keep;
  logic [CntW-1:0]      kept_nxt;
  logic                 walk_end;
  logic                 lower_end;

  assign act          = action_e'(action_i);
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign out_load     = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // stack geometry
  assign cnt_m1       = count_q - 1'b1;
  assign top_idx      = cnt_m1[IdxW-1:0];
  assign top_m1       = top_idx - 1'b1;
  assign full         = (count_q == CntW'(MaxLayers));
  assign push_idx     = full ? IdxW'(MaxLayers - 1) : count_q[IdxW-1:0];
  assign pend_instant = (pend_time_q < TimeW'(InstantThreshold));

  // top layer elapsed time, saturating
  assign dur_top      = dur_q[top_idx];
  assign elap_sum     = {1'b0, elap_q[top_idx]} + {1'b0, frame_q};
  assign elap_sat     = elap_sum[TimeW] ? '1 : elap_sum[TimeW-1:0];
  assign top_complete = (dur_top == '0) || (elap_sat >= dur_top);

  // one restoring division step per cycle
  assign rem2         = {rem_q, 1'b0};
  assign rem_sub      = rem2 - {1'b0, dur_top};
  assign div_ge       = (rem2 >= {1'b0, dur_top});
  assign rem_nxt      = div_ge ? rem_sub[TimeW-1:0] : rem2[TimeW-1:0];
  assign quo_nxt      = {quo_q[WeightBits-2:0], div_ge};

  // shared multiplier for the lower layers
  assign fade_f       = One - tw_q;
  assign prod         = peak_q[idx_q] * fade_f;

  // compaction and walk bookkeeping
  assign keep         = (wgt_q[idx_q] != '0);
  assign kept_nxt     = kept_q + CntW'(keep);
  assign walk_end     = (CntW'(idx_q) == cnt_m1);
  assign lower_end    = (idx_q == top_m1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && act == ACT_TICK) begin
          state_d = pend_valid_q ? ST_APPLY : ST_FADE;
        end
      end
      ST_APPLY: begin
        state_d = ST_FADE;
      end
      ST_FADE: begin
        priority if (count_q == '0) begin
          state_d = ST_IDLE;
        end else if (count_q == CntW'(1)) begin
          state_d = ST_COMPACT;
        end else if (top_complete) begin
          state_d = ST_LOWER;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (divcnt_q == '0) begin
          state_d = ST_LOWER;
        end
      end
      ST_LOWER: begin
        if (lower_end) begin
          state_d = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (walk_end) begin
          state_d = (kept_nxt == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && walk_end) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      kept_q       <= '0;
      divcnt_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_chart_q <= '0;
      pend_time_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (act)
              ACT_ADD: begin
                pend_valid_q <= 1'b1;
                pend_chart_q <= chart_id_i;
                pend_time_q  <= fade_time_i;
              end
              ACT_CLEAR: begin
                count_q      <= '0;
                pend_valid_q <= 1'b0;
                pend_chart_q <= '0;
                pend_time_q  <= '0;
              end
              ACT_TICK, ACT_NOP: begin
              end
            endcase
          end
        end
        ST_APPLY: begin
          pend_valid_q <= 1'b0;
          priority if (pend_instant) begin
            count_q <= CntW'(1);
          end else if (full) begin
            count_q <= CntW'(MaxLayers);
          end else begin
            count_q <= count_q + 1'b1;
          end
        end
        ST_FADE: begin
          idx_q    <= '0;
          kept_q   <= '0;
          divcnt_q <= DivCntW'(WeightBits - 1);
        end
        ST_DIV: begin
          divcnt_q <= divcnt_q - 1'b1;
        end
        ST_LOWER: begin
          idx_q <= lower_end ? '0 : idx_q + 1'b1;
        end
        ST_COMPACT: begin
          kept_q <= kept_nxt;
          idx_q  <= walk_end ? '0 : idx_q + 1'b1;
          if (walk_end) begin
            count_q <= kept_nxt;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            idx_q <= idx_q + 1'b1;
          end
        end
      endcase

      // output register valid
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // layer stack and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= frame_time_i;
    end

    unique case (state_q)
      ST_APPLY: begin
        if (pend_instant) begin
          ids_q[0]  <= pend_chart_q;
          wgt_q[0]  <= One;
          peak_q[0] <= One;
          elap_q[0] <= '0;
          dur_q[0]  <= '0;
        end else begin
          // freeze peaks, dropping the oldest layer when full
          for (int i = 0; i < MaxLayers - 1; i++) begin
            if (full) begin
              ids_q[i]  <= ids_q[i+1];
              wgt_q[i]  <= wgt_q[i+1];
              peak_q[i] <= wgt_q[i+1];
              elap_q[i] <= elap_q[i+1];
              dur_q[i]  <= dur_q[i+1];
            end else if (IdxW'(i) != push_idx) begin
              peak_q[i] <= wgt_q[i];
            end
          end
          // push the new layer at weight zero
          ids_q[push_idx]  <= pend_chart_q;
          wgt_q[push_idx]  <= '0;
          peak_q[push_idx] <= One;
          elap_q[push_idx] <= '0;
          dur_q[push_idx]  <= pend_time_q;
        end
      end
      ST_FADE: begin
        if (count_q == CntW'(1)) begin
          wgt_q[0] <= One;
        end else if (count_q != '0) begin
          elap_q[top_idx] <= elap_sat;
          if (top_complete) begin
            tw_q           <= One;
            wgt_q[top_idx] <= One;
          end else begin
            rem_q <= elap_sat;
            quo_q <= '0;
          end
        end
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= quo_nxt;
        if (divcnt_q == '0) begin
          tw_q           <= {1'b0, quo_nxt};
          wgt_q[top_idx] <= {1'b0, quo_nxt};
        end
      end
      ST_LOWER: begin
        wgt_q[idx_q] <= prod[WeightBits +: WeightW];
      end
      ST_COMPACT: begin
        // move surviving layers down to close gaps
        if (keep) begin
          ids_q[kept_q[IdxW-1:0]]  <= ids_q[idx_q];
          wgt_q[kept_q[IdxW-1:0]]  <= wgt_q[idx_q];
          peak_q[kept_q[IdxW-1:0]] <= peak_q[idx_q];
          elap_q[kept_q[IdxW-1:0]] <= elap_q[idx_q];
          dur_q[kept_q[IdxW-1:0]]  <= dur_q[idx_q];
        end
      end
      ST_IDLE, ST_EMIT: begin
      end
    endcase

    // output payload
    if (out_load) begin
      out_chart_q  <= ids_q[idx_q];
      out_weight_q <= wgt_q[idx_q];
      out_last_q   <= walk_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign layer_chart_o  = out_chart_q;
  assign layer_weight_o = out_weight_q;
  assign last_layer_o   = out_last_q;

  // checks
  `ASSERT_ALWAYS(a_count_range, count_q <= CntW'(MaxLayers), "layer count above stack depth")
  `ASSERT_IMPLIES(a_div_rem, state_q == ST_DIV, rem_q < dur_top, "divider remainder not below divisor")
  `ASSERT_IMPLIES(a_emit_idx, state_q == ST_EMIT, CntW'(idx_q) < count_q, "emit index past layer count")
  `ASSERT_IMPLIES(a_out_nonzero, out_valid_o, layer_weight_o != '0, "emitted layer has zero weight")

endmodule

### verif/lut_layer_crossfade_checker.sv
// layer stack predictor and result checker for the lut layer crossfade controller
module lut_layer_crossfade_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    action_i,
  input  logic [lutxf_pkg::IdW-1:0]     chart_id_i,
  input  logic [lutxf_pkg::TimeW-1:0]   fade_time_i,
  input  logic [lutxf_pkg::TimeW-1:0]   frame_time_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [lutxf_pkg::IdW-1:0]     layer_chart_i,
  input  logic [lutxf_pkg::WeightW-1:0] layer_weight_i,
  input  logic                          last_layer_i,
  output int                            fail_count_o,
  output int                            expected_left_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lutxf_pkg::*;

  // one entry of the modeled grading stack
  typedef struct packed {
    logic [IdW-1:0]     chart;
    logic [WeightW-1:0] weight;
    logic [WeightW-1:0] peak;
    logic [TimeW-1:0]   elapsed;
    logic [TimeW-1:0]   dur;
  } grade_layer_t;

  // one emitted layer as seen on the result channel
  typedef struct packed {
    logic [IdW-1:0]     chart;
    logic [WeightW-1:0] weight;
    logic               last;
  } blend_out_t;

  grade_layer_t     grade_stack [MaxLayers];
  int               layer_cnt = 0;
  bit               pend_vld = 1'b0;
  logic [IdW-1:0]   pend_chart = '0;
  logic [TimeW-1:0] pend_time = '0;
  blend_out_t       expected_layers [$];
  int               mismatches = 0;

  // one printed line per failure
  task automatic report_mismatch(string what);
    $display("%0t: layer check failed, %s", $realtime, what);
    mismatches++;
  endtask

  // fold the latched chart into the stack
  function automatic void fold_pending_chart();
    if (pend_time < InstantThreshold) begin
      layer_cnt = 1;
      grade_stack[0] = '{chart: pend_chart, weight: One, peak: One, elapsed: '0, dur: '0};
    end else begin
      for (int i = 0; i < layer_cnt; i++) grade_stack[i].peak = grade_stack[i].weight;
      // full stack drops its oldest layer
      if (layer_cnt >= MaxLayers) begin
        for (int i = 1; i < MaxLayers; i++) grade_stack[i-1] = grade_stack[i];
        layer_cnt = MaxLayers - 1;
      end
      grade_stack[layer_cnt] = '{chart: pend_chart, weight: '0, peak: One, elapsed: '0,
                                 dur: pend_time};
      layer_cnt++;
    end
  endfunction

  // fold any latched chart, fade, drop empty layers and queue the emitted list
  function automatic void predict_tick(logic [TimeW-1:0] frame);
    int          top;
    int          kept;
    logic [TimeW:0] run;
    logic [63:0] top_w;
    if (pend_vld) begin
      fold_pending_chart();
      pend_vld = 1'b0;
    end
    if (layer_cnt == 1) begin
      grade_stack[0].weight = One;
    end else if (layer_cnt > 1) begin
      top = layer_cnt - 1;
      run = {1'b0, grade_stack[top].elapsed} + {1'b0, frame};
      if (run > {1'b0, {TimeW{1'b1}}}) run = {1'b0, {TimeW{1'b1}}};
      grade_stack[top].elapsed = run[TimeW-1:0];
      if (grade_stack[top].dur == '0) begin
        top_w = 64'(One);
      end else begin
        top_w = (64'(run) << WeightBits) / 64'(grade_stack[top].dur);
        if (top_w > 64'(One)) top_w = 64'(One);
      end
      grade_stack[top].weight = top_w[WeightW-1:0];
      for (int i = 0; i < top; i++) begin
        grade_stack[i].weight =
          WeightW'((64'(grade_stack[i].peak) * (64'(One) - top_w)) >> WeightBits);
      end
    end
    kept = 0;
    for (int i = 0; i < layer_cnt; i++) begin
      if (grade_stack[i].weight != '0) begin
        grade_stack[kept] = grade_stack[i];
        kept++;
      end
    end
    layer_cnt = kept;
    for (int i = 0; i < layer_cnt; i++) begin
      expected_layers.push_back('{chart: grade_stack[i].chart,
                                  weight: grade_stack[i].weight,
                                  last: (i == layer_cnt - 1)});
    end
  endfunction

  // predict on each accepted request, compare each accepted layer
  always @(posedge clk_i or negedge rst_ni) begin
    blend_out_t want;
    if (!rst_ni) begin
      layer_cnt = 0;
      pend_vld = 1'b0;
      pend_chart = '0;
      pend_time = '0;
      expected_layers.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (action_e'(action_i))
          ACT_TICK: begin
            predict_tick(frame_time_i);
          end
          ACT_ADD: begin
            pend_vld = 1'b1;
            pend_chart = chart_id_i;
            pend_time = fade_time_i;
          end
          ACT_CLEAR: begin
            layer_cnt = 0;
            pend_vld = 1'b0;
            pend_chart = '0;
            pend_time = '0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_layers.size() == 0) begin
          report_mismatch($sformatf("layer chart %h weight %h last %b with none expected",
                                    layer_chart_i, layer_weight_i, last_layer_i));
        end else begin
          want = expected_layers.pop_front();
          if (layer_chart_i !== want.chart)
            report_mismatch($sformatf("chart %h, expected %h", layer_chart_i, want.chart));
          if (layer_weight_i !== want.weight)
            report_mismatch($sformatf("weight %h, expected %h (chart %h)",
                                      layer_weight_i, want.weight, want.chart));
          if (last_layer_i !== want.last)
            report_mismatch($sformatf("last flag %b, expected %b (chart %h)",
                                      last_layer_i, want.last, want.chart));
        end
      end
    end
    expected_left_o <= expected_layers.size();
    fail_count_o <= mismatches;
  end

endmodule

### verif/lut_layer_crossfade_controller_top_tb.sv
// stimulus and verdict for the lut layer crossfade controller
module lut_layer_crossfade_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lutxf_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  action_e            action = ACT_TICK;
  logic [IdW-1:0]     chart_id = '0;
  logic [TimeW-1:0]   fade_time = '0;
  logic [TimeW-1:0]   frame_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IdW-1:0]     layer_chart;
  logic [WeightW-1:0] layer_weight;
  logic               last_layer;
  int                 fail_count;
  int                 expected_left;
  bit                 send_calm = 1'b0;
  bit                 recv_calm = 1'b0;

  lut_layer_crossfade_controller_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .chart_id_i     (chart_id),
    .fade_time_i    (fade_time),
    .frame_time_i   (frame_time),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .layer_chart_o  (layer_chart),
    .layer_weight_o (layer_weight),
    .last_layer_o   (last_layer)
  );

  lut_layer_crossfade_checker u_layer_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .chart_id_i      (chart_id),
    .fade_time_i     (fade_time),
    .frame_time_i    (frame_time),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .layer_chart_i   (layer_chart),
    .layer_weight_i  (layer_weight),
    .last_layer_i    (last_layer),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // offer one request after a random gap and hold it until taken
  task automatic send_request(action_e act, logic [IdW-1:0] chart, logic [TimeW-1:0] fade,
                              logic [TimeW-1:0] frame);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    chart_id <= chart;
    fade_time <= fade;
    frame_time <= frame;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // directed requests, random requests, drain and verdict
  initial begin
    int unsigned   counted;
    int unsigned   pick;
    action_e       act;
    logic [TimeW-1:0] fade;
    logic [TimeW-1:0] frame;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty stack, unused action
    send_request(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_NOP, 16'h1234, 16'h0000, 16'h0000);
    // instant chart at fade zero
    send_request(ACT_ADD, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    // later add overwrites the latched one, fade just under the threshold
    send_request(ACT_ADD, 16'h1234, 16'd50000, 16'h0000);
    send_request(ACT_ADD, 16'h0000, 16'(InstantThreshold - 1), 16'h0000);
    send_request(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // fade at the threshold with no elapsed time: new top drops out at once
    send_request(ACT_ADD, 16'hA5A5, 16'(InstantThreshold), 16'h0000);
    send_request(ACT_TICK, 16'h5A5A, 16'h0000, 16'h0000);
    // slow fades stacked past the full depth
    for (int k = 0; k < MaxLayers; k++) begin
      send_request(ACT_ADD, 16'h0100 + 16'(k), 16'd1000, 16'h0000);
      send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0001);
    end
    // elapsed saturates, top completes and the rest fade out
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'hFFFF);
    send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0040);

    // random traffic, mostly slow fades so the stack gets deep
    counted = 0;
    while (counted < 400) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) act = ACT_TICK;
      else if (pick < 93) act = ACT_ADD;
      else if (pick < 96) act = ACT_CLEAR;
      else act = ACT_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 12) fade = TimeW'($urandom_range(0, InstantThreshold - 1));
      else if (pick < 16) fade = TimeW'(InstantThreshold);
      else if (pick < 84) fade = TimeW'($urandom_range(InstantThreshold, 4000));
      else fade = TimeW'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 10) frame = '0;
      else if (pick < 72) frame = TimeW'($urandom_range(1, 40));
      else if (pick < 94) frame = TimeW'($urandom());
      else frame = '1;
      send_request(act, IdW'($urandom()), fade, frame);
      counted++;
    end
    in_valid <= 1'b0;

    // let the last prediction land, drain, then watch for stray results
    repeat (2) @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && expected_left == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          held;
    taken = 0;
    held = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      if (!held && taken == 60) begin
        held = 1'b1;
        gap = 400;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      taken++;
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/lutxf_pkg.sv
hdl/lut_layer_crossfade_controller_top.sv
verif/lut_layer_crossfade_checker.sv
verif/lut_layer_crossfade_controller_top_tb.sv
